@@ hdl/kmer_counting_table_top_assert.svh @@
// ----------------------------------------------------------------------------
// kmer_counting_table_top_assert.svh
// Assertion macros used by the k-mer counting table RTL.
// ----------------------------------------------------------------------------
`ifndef KMER_COUNTING_TABLE_TOP_ASSERT_SVH
`define KMER_COUNTING_TABLE_TOP_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define KCT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kct assertion failed");

// next-cycle implication, clocked on clock, off during reset
`define KCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kct assertion failed");

`endif

@@ hdl/kct_pkg.sv @@
// ----------------------------------------------------------------------------
// kct_pkg
// Field widths, command and status codes of the k-mer counting table.
// ----------------------------------------------------------------------------
package kct_pkg;

   localparam int CMD_W      = 2;
   localparam int SYMBOL_W   = 8;
   localparam int KEY_W      = 64;
   localparam int LEN_W      = 4;
   localparam int STATUS_W   = 3;
   localparam int INDEX_W    = 10;
   localparam int COUNT_W    = 32;
   localparam int DISTINCT_W = 11;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0] LEN_RESET = 4'd4;

   typedef enum logic [CMD_W-1:0] {
      CMD_SYMBOL = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FILLING = 3'd0,
      ST_COUNTED = 3'd1,
      ST_NEW     = 3'd2,
      ST_FULL    = 3'd3,
      ST_HIT     = 3'd4,
      ST_MISS    = 3'd5,
      ST_CLEARED = 3'd6
   } status_type;

   // register index 0 sits at byte address 0
   localparam logic REG_KMER_LENGTH = 1'b0;

endpackage

@@ hdl/kmer_counting_table_top.sv @@
// ----------------------------------------------------------------------------
// kmer_counting_table_top
// Sliding-window k-mer counter over an insertion-ordered key table.
// ----------------------------------------------------------------------------
// One item at a time. A sequence byte or query walks the stored keys in
// insertion order through one compare unit fed by the key memory, one entry
// per cycle, comparing entries up to the first hit, else all stored entries.
// Clear, unused and window-filling items skip the scan and go straight to
// EMIT. The result sits in an output register, and the next item is taken
// while it waits.
`include "kmer_counting_table_top_assert.svh"

module kmer_counting_table_top #(
   parameter int CAPACITY   = 1024,
   parameter int MAX_K      = 8,
   parameter int COUNT_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [kct_pkg::CMD_W-1:0]        req_command,
   input  logic [kct_pkg::SYMBOL_W-1:0]     req_symbol,
   input  logic                             req_starts_sequence,
   input  logic [kct_pkg::KEY_W-1:0]        req_query_key,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [kct_pkg::STATUS_W-1:0]     rsp_status,
   output logic [kct_pkg::INDEX_W-1:0]      rsp_entry_index,
   output logic [kct_pkg::COUNT_W-1:0]      rsp_entry_count,
   output logic [kct_pkg::DISTINCT_W-1:0]   rsp_distinct_kmers,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [kct_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [kct_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [kct_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import kct_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int TOT_W  = $clog2(CAPACITY + 1);
   localparam int FILL_W = $clog2(MAX_K + 1);
   localparam int WIN_W  = 8 * MAX_K;

   localparam logic [TOT_W-1:0]  CAP_TOT    = TOT_W'(CAPACITY);
   localparam logic [LEN_W-1:0]  MAX_K_LEN  = LEN_W'(MAX_K);
   localparam logic [FILL_W-1:0] MAX_K_FILL = FILL_W'(MAX_K);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [LEN_W-1:0]          klen_ff, klen_in;
   logic [WIN_W-1:0]          window_ff, window_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [TOT_W-1:0]          total_ff, total_in;
   logic [KEY_W-1:0]          key_ff, key_in;
   logic                      is_query_ff, is_query_in;
   logic [TOT_W-1:0]          scan_addr_ff, scan_addr_in;
   logic                      chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]          chk_addr_ff, chk_addr_in;
   status_type                res_status_ff, res_status_in;
   logic [IDX_W-1:0]          res_index_ff, res_index_in;
   logic [COUNT_BITS-1:0]     res_count_ff, res_count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [DISTINCT_W-1:0]     rsp_distinct_ff, rsp_distinct_in;

   logic [KEY_W-1:0]          key_mem [CAPACITY];
   logic [COUNT_BITS-1:0]     cnt_mem [CAPACITY];
   logic [KEY_W-1:0]          key_rd_ff;
   logic [COUNT_BITS-1:0]     cnt_rd_ff;
   logic                      key_we;
   logic                      cnt_we;
   logic [IDX_W-1:0]          mem_waddr;
   logic [COUNT_BITS-1:0]     cnt_wdata;
   logic [IDX_W-1:0]          mem_raddr;

   logic                      cfg_write;
   logic [LEN_W-1:0]          k_eff;
   logic [WIN_W-1:0]          win_base;
   logic [WIN_W-1:0]          win_next;
   logic [FILL_W-1:0]         fill_base;
   logic [FILL_W-1:0]         fill_next;
   logic [KEY_W-1:0]          win_key;
   logic [KEY_W-1:0]          masked_key;
   logic                      filling;
   logic                      match;
   logic [COUNT_BITS-1:0]     cnt_inc;
   logic [31:0]               idx_wide;
   logic [31:0]               tot_wide;

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_distinct_kmers = rsp_distinct_ff;

   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == REG_KMER_LENGTH) ? CSR_DATA_W'(klen_ff) : '0;

   assign klen_in = (cfg_write && paddr[2] == REG_KMER_LENGTH) ? pwdata[LEN_W-1:0] : klen_ff;

   always_comb begin
      if (klen_ff == '0) begin
         k_eff = LEN_W'(1);
      end else if (klen_ff > MAX_K_LEN) begin
         k_eff = MAX_K_LEN;
      end else begin
         k_eff = klen_ff;
      end
   end

   // window as it stands after taking this item's byte
   assign win_base  = req_starts_sequence ? '0 : window_ff;
   assign win_next  = (win_base << 8) | WIN_W'(req_symbol);
   assign fill_base = req_starts_sequence ? '0 : fill_ff;
   assign fill_next = (fill_base < MAX_K_FILL) ? fill_base + FILL_W'(1) : fill_base;
   assign filling   = LEN_W'(fill_next) < k_eff;
   assign win_key   = KEY_W'(win_next);

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         masked_key[8*b +: 8] = (LEN_W'(b) < k_eff) ? win_key[8*b +: 8] : 8'h00;
      end
   end

   assign match   = chk_valid_ff && (key_rd_ff == key_ff);
   assign cnt_inc = (cnt_rd_ff == '1) ? cnt_rd_ff : cnt_rd_ff + COUNT_BITS'(1);

   assign mem_raddr = scan_addr_ff[IDX_W-1:0];
   assign idx_wide  = 32'(res_index_ff);
   assign tot_wide  = 32'(total_ff);

   always_comb begin
      state_in        = state_ff;
      window_in       = window_ff;
      fill_in         = fill_ff;
      total_in        = total_ff;
      key_in          = key_ff;
      is_query_in     = is_query_ff;
      scan_addr_in    = scan_addr_ff;
      chk_valid_in    = chk_valid_ff;
      chk_addr_in     = chk_addr_ff;
      res_status_in   = res_status_ff;
      res_index_in    = res_index_ff;
      res_count_in    = res_count_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_distinct_in = rsp_distinct_ff;
      key_we          = 1'b0;
      cnt_we          = 1'b0;
      mem_waddr       = chk_addr_ff;
      cnt_wdata       = cnt_inc;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               res_status_in = ST_FILLING;
               res_index_in  = '0;
               res_count_in  = '0;
               scan_addr_in  = '0;
               chk_valid_in  = 1'b0;
               state_in      = EMIT;
               case (cmd_type'(req_command))
                  CMD_SYMBOL: begin
                     window_in   = win_next;
                     fill_in     = fill_next;
                     key_in      = masked_key;
                     is_query_in = 1'b0;
                     if (!filling) begin
                        state_in = SCAN;
                     end
                  end
                  CMD_QUERY: begin
                     key_in      = req_query_key;
                     is_query_in = 1'b1;
                     state_in    = SCAN;
                  end
                  CMD_CLEAR: begin
                     total_in      = '0;
                     res_status_in = ST_CLEARED;
                  end
                  default: begin
                     res_status_in = ST_FILLING;
                  end
               endcase
            end
         end
         SCAN: begin
            if (match) begin
               chk_valid_in = 1'b0;
               res_index_in = chk_addr_ff;
               state_in     = EMIT;
               if (is_query_ff) begin
                  res_status_in = ST_HIT;
                  res_count_in  = cnt_rd_ff;
               end else begin
                  res_status_in = ST_COUNTED;
                  res_count_in  = cnt_inc;
                  cnt_we        = 1'b1;
               end
            end else if (scan_addr_ff == total_ff) begin
               chk_valid_in = 1'b0;
               res_index_in = '0;
               res_count_in = '0;
               state_in     = EMIT;
               if (is_query_ff) begin
                  res_status_in = ST_MISS;
               end else if (total_ff == CAP_TOT) begin
                  res_status_in = ST_FULL;
               end else begin
                  res_status_in = ST_NEW;
                  res_index_in  = total_ff[IDX_W-1:0];
                  res_count_in  = COUNT_BITS'(1);
                  mem_waddr     = total_ff[IDX_W-1:0];
                  cnt_wdata     = COUNT_BITS'(1);
                  key_we        = 1'b1;
                  cnt_we        = 1'b1;
                  total_in      = total_ff + TOT_W'(1);
               end
            end else begin
               chk_valid_in = 1'b1;
               chk_addr_in  = scan_addr_ff[IDX_W-1:0];
               scan_addr_in = scan_addr_ff + TOT_W'(1);
            end
         end
         EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_index_in    = idx_wide[INDEX_W-1:0];
               rsp_count_in    = COUNT_W'(res_count_ff);
               rsp_distinct_in = tot_wide[DISTINCT_W-1:0];
               state_in        = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         klen_ff      <= LEN_RESET;
         window_ff    <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         klen_ff         <= klen_in;
         window_ff       <= window_in;
         fill_ff         <= fill_in;
         total_ff        <= total_in;
         chk_valid_ff    <= chk_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         key_ff          <= key_in;
         is_query_ff     <= is_query_in;
         scan_addr_ff    <= scan_addr_in;
         chk_addr_ff     <= chk_addr_in;
         res_status_ff   <= res_status_in;
         res_index_ff    <= res_index_in;
         res_count_ff    <= res_count_in;
         rsp_status_ff   <= rsp_status_in;
         rsp_index_ff    <= rsp_index_in;
         rsp_count_ff    <= rsp_count_in;
         rsp_distinct_ff <= rsp_distinct_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[mem_waddr] <= key_ff;
      end
      key_rd_ff <= key_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[mem_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[mem_raddr];
   end

   `KCT_ASSERT_NOW(a_total_bound, 1'b1, total_ff <= CAP_TOT)
   `KCT_ASSERT_NEXT(a_accept_blocks, req_valid && !req_stall, req_stall)
   `KCT_ASSERT_NEXT(a_insert_grows, key_we, total_ff == $past(total_ff) + TOT_W'(1))
   `KCT_ASSERT_NOW(a_rsp_from_emit, $rose(rsp_valid_ff), $past(state_ff) == EMIT)
   `KCT_ASSERT_NOW(a_new_count_one, rsp_valid_ff && rsp_status_ff == ST_NEW, rsp_count_ff == COUNT_W'(1))

endmodule

@@ bench/kmer_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_table_checker
// Watches the item, result and register ports of the k-mer counting table.
// It keeps its own copy of the window, the key table and the length register,
// predicts one result per accepted item, and compares every accepted result
// field by field with the oldest prediction. It reports the failure count and
// the number of results still outstanding.
// ----------------------------------------------------------------------------
module kmer_table_checker #(
   parameter int CAPACITY   = 1024,
   parameter int MAX_K      = 8,
   parameter int COUNT_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [kct_pkg::CMD_W-1:0]        req_command,
   input  logic [kct_pkg::SYMBOL_W-1:0]     req_symbol,
   input  logic                             req_starts_sequence,
   input  logic [kct_pkg::KEY_W-1:0]        req_query_key,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [kct_pkg::STATUS_W-1:0]     rsp_status,
   input  logic [kct_pkg::INDEX_W-1:0]      rsp_entry_index,
   input  logic [kct_pkg::COUNT_W-1:0]      rsp_entry_count,
   input  logic [kct_pkg::DISTINCT_W-1:0]   rsp_distinct_kmers,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [kct_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [kct_pkg::CSR_DATA_W-1:0]   pwdata,
   input  logic                             pready,
   output int                               fail_count,
   output int                               pending
);
   import kct_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] KMER_LENGTH_ADDR = CSR_ADDR_W'(4 * REG_KMER_LENGTH);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'((64'd1 << COUNT_BITS) - 64'd1);

   typedef struct packed {
      status_type             status;
      logic [INDEX_W-1:0]     index;
      logic [COUNT_W-1:0]     count;
      logic [DISTINCT_W-1:0]  distinct;
   } tally_type;

   tally_type          expected_tallies[$];
   logic [LEN_W-1:0]   length_reg = LEN_RESET;
   logic [KEY_W-1:0]   seq_window = '0;
   int                 window_len = 0;
   logic [KEY_W-1:0]   table_keys [CAPACITY];
   logic [COUNT_W-1:0] table_counts [CAPACITY];
   int                 table_size = 0;
   int                 errors = 0;

   function automatic int lookup_key(logic [KEY_W-1:0] key);
      for (int i = 0; i < table_size; i++) begin
         if (table_keys[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic tally_type count_item(logic [CMD_W-1:0] cmd, logic [SYMBOL_W-1:0] sym,
                                            logic restart, logic [KEY_W-1:0] qkey);
      tally_type        r;
      int               k;
      int               pos;
      logic [KEY_W-1:0] key;
      r = '0;
      r.status = ST_FILLING;
      k = (length_reg == 0) ? 1 : ((int'(length_reg) > MAX_K) ? MAX_K : int'(length_reg));
      case (cmd_type'(cmd))
         CMD_SYMBOL: begin
            if (restart) begin
               seq_window = '0;
               window_len = 0;
            end
            seq_window = {seq_window[KEY_W-9:0], sym};
            if (window_len < MAX_K) window_len++;
            if (window_len >= k) begin
               key = (k >= 8) ? seq_window : seq_window & ((64'd1 << (8 * k)) - 64'd1);
               pos = lookup_key(key);
               if (pos >= 0) begin
                  if (table_counts[pos] < COUNT_MAX) table_counts[pos] += 1;
                  r.status = ST_COUNTED;
                  r.index  = INDEX_W'(pos);
                  r.count  = table_counts[pos];
               end else if (table_size >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  table_keys[table_size]   = key;
                  table_counts[table_size] = 1;
                  r.status = ST_NEW;
                  r.index  = INDEX_W'(table_size);
                  r.count  = 1;
                  table_size++;
               end
            end
         end
         CMD_QUERY: begin
            pos = lookup_key(qkey);
            if (pos >= 0) begin
               r.status = ST_HIT;
               r.index  = INDEX_W'(pos);
               r.count  = table_counts[pos];
            end else begin
               r.status = ST_MISS;
            end
         end
         CMD_CLEAR: begin
            table_size = 0;
            r.status = ST_CLEARED;
         end
         default: ;
      endcase
      r.distinct = DISTINCT_W'(table_size);
      return r;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      tally_type want;
      if (reset) begin
         expected_tallies.delete();
         length_reg = LEN_RESET;
         seq_window = '0;
         window_len = 0;
         table_size = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == KMER_LENGTH_ADDR) begin
            length_reg = pwdata[LEN_W-1:0];
         end
         if (req_valid && !req_stall) begin
            expected_tallies.push_back(count_item(req_command, req_symbol,
                                                  req_starts_sequence, req_query_key));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_tallies.size() == 0) begin
               $error("result with no item outstanding: status %0d", rsp_status);
               errors++;
            end else begin
               want = expected_tallies.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_status));
               compare_field("entry_index", 64'(want.index), 64'(rsp_entry_index));
               compare_field("entry_count", 64'(want.count), 64'(rsp_entry_count));
               compare_field("distinct_kmers", 64'(want.distinct), 64'(rsp_distinct_kmers));
            end
         end
      end
      pending    <= expected_tallies.size();
      fail_count <= errors;
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the k-mer counting table.
// A directed run covers empty-table queries, the unused command, case
// sensitivity, zero and all-ones bytes and wide query keys. Random segments
// then sweep the k-mer length, including out-of-range values, under three
// idle patterns and one long result hold-off. A last phase fills the table to
// capacity and checks dropped k-mers. Checking is done in kmer_table_checker.
// ----------------------------------------------------------------------------
module testbench;
   import kct_pkg::*;

   localparam int TABLE_CAPACITY = 1024;
   localparam int CYCLE_LIMIT    = 4000000;
   localparam int HOLD_CYCLES    = 150;
   localparam int SEG_ITEMS      = 15;
   localparam logic [CSR_ADDR_W-1:0] KMER_LENGTH_ADDR = CSR_ADDR_W'(4 * REG_KMER_LENGTH);
   localparam logic [LEN_W-1:0] LENGTH_PLAN [12] = '{
      4'd0, 4'd1, 4'd8, 4'd15, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd1, 4'd4
   };
   localparam logic [SYMBOL_W-1:0] BASES [8] = '{
      8'h41, 8'h43, 8'h47, 8'h54, 8'h61, 8'h63, 8'h67, 8'h74
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_command = CMD_SYMBOL;
   logic [SYMBOL_W-1:0]     req_symbol = '0;
   logic                    req_starts_sequence = 1'b0;
   logic [KEY_W-1:0]        req_query_key = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic [INDEX_W-1:0]      rsp_entry_index;
   logic [COUNT_W-1:0]      rsp_entry_count;
   logic [DISTINCT_W-1:0]   rsp_distinct_kmers;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr = '0;
   logic [CSR_DATA_W-1:0]   pwdata = '0;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   int               fail_count;
   int               pending;
   int               gap_pct = 15;
   int               stall_pct = 76;
   int               hold_requests = 0;
   int               hold_seen = 0;
   int               hold_left = 0;
   int               cycle_count = 0;
   int               eff_k = 4;
   int               alphabet_size = 4;
   logic [KEY_W-1:0] recent_bytes = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   kmer_counting_table_top #(
      .CAPACITY (TABLE_CAPACITY)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_symbol          (req_symbol),
      .req_starts_sequence (req_starts_sequence),
      .req_query_key       (req_query_key),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_distinct_kmers  (rsp_distinct_kmers),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   kmer_table_checker #(
      .CAPACITY (TABLE_CAPACITY)
   ) table_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_symbol          (req_symbol),
      .req_starts_sequence (req_starts_sequence),
      .req_query_key       (req_query_key),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_distinct_kmers  (rsp_distinct_kmers),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .pready              (pready),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   // result side: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [KEY_W-1:0] window_mask(int k);
      return (k >= 8) ? {KEY_W{1'b1}} : (64'd1 << (8 * k)) - 64'd1;
   endfunction

   task automatic send_item(cmd_type cmd, logic [SYMBOL_W-1:0] sym, logic restart,
                            logic [KEY_W-1:0] key);
      if (cmd == CMD_SYMBOL) begin
         if (restart) recent_bytes = '0;
         recent_bytes = {recent_bytes[KEY_W-9:0], sym};
      end
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_symbol          <= sym;
      req_starts_sequence <= restart;
      req_query_key       <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_kmer_length(logic [LEN_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= KMER_LENGTH_ADDR;
      pwdata  <= ($urandom & ~32'hF) | CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      eff_k = (value == 0) ? 1 : ((int'(value) > 8) ? 8 : int'(value));
   endtask

   initial begin
      int                  seg;
      int                  n;
      int                  pick;
      logic [SYMBOL_W-1:0] sym;
      logic                restart;
      logic [KEY_W-1:0]    key;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, at the reset length of 4
      send_item(CMD_QUERY, 8'h00, 1'b0, 64'd0);
      send_item(CMD_UNUSED, 8'hFF, 1'b1, {KEY_W{1'b1}});
      send_item(CMD_CLEAR, 8'h00, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'h41, 1'b1, 64'd0);
      send_item(CMD_SYMBOL, 8'h43, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'h67, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'h74, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'h41, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'h41, 1'b1, 64'd0);
      send_item(CMD_SYMBOL, 8'h43, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'h67, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'h74, 1'b0, 64'd0);
      send_item(CMD_QUERY, 8'h00, 1'b0, 64'h4143_6774);
      send_item(CMD_QUERY, 8'h00, 1'b0, 64'hFF00_0000_4143_6774);
      // lower case differs from upper case
      send_item(CMD_SYMBOL, 8'h61, 1'b1, 64'd0);
      send_item(CMD_SYMBOL, 8'h43, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'h67, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'h74, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'h00, 1'b1, 64'd0);
      send_item(CMD_SYMBOL, 8'h00, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'hFF, 1'b0, 64'd0);
      send_item(CMD_SYMBOL, 8'hFF, 1'b0, 64'd0);
      send_item(CMD_QUERY, 8'h00, 1'b0, {KEY_W{1'b1}});
      send_item(CMD_CLEAR, 8'h00, 1'b0, 64'd0);
      send_item(CMD_QUERY, 8'h00, 1'b0, 64'h4143_6774);
      wait_for_results();

      for (seg = 0; seg < 12; seg++) begin
         if (seg < 4) begin
            gap_pct   = 15;
            stall_pct = 76;
         end else if (seg < 8) begin
            gap_pct   = 76;
            stall_pct = 15;
         end else begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         write_kmer_length(LENGTH_PLAN[seg]);
         for (n = 0; n < SEG_ITEMS; n++) begin
            if (seg == 8 && n == 5) hold_requests <= hold_requests + 1;
            sym     = SYMBOL_W'($urandom);
            restart = 1'($urandom);
            key     = {$urandom, $urandom};
            pick    = $urandom_range(99);
            if (pick < 3) begin
               send_item(CMD_CLEAR, sym, restart, key);
            end else if (pick < 5) begin
               send_item(CMD_UNUSED, sym, restart, key);
            end else if (pick < 25) begin
               pick = $urandom_range(99);
               if (pick < 50) begin
                  key = recent_bytes & window_mask(eff_k);
               end else if (pick < 65) begin
                  key = (recent_bytes & window_mask(eff_k)) | (key & ~window_mask(eff_k));
               end else if (pick < 80) begin
                  key = KEY_W'($urandom_range(255));
               end
               send_item(CMD_QUERY, sym, restart, key);
            end else begin
               restart = ($urandom_range(99) < 6);
               if (restart) alphabet_size = $urandom_range(1, 8);
               if ($urandom_range(99) >= 10) sym = BASES[$urandom_range(alphabet_size - 1)];
               send_item(CMD_SYMBOL, sym, restart, key);
            end
         end
         wait_for_results();
      end

      // one byte stream through all bytes at odd strides 1, 3, 5, 7, then 9, gives
      // distinct two-byte k-mers until the table is full, then drops
      write_kmer_length(4'd2);
      send_item(CMD_CLEAR, 8'h00, 1'b0, 64'd0);
      for (n = 0; n < TABLE_CAPACITY + 8; n++) begin
         send_item(CMD_SYMBOL, SYMBOL_W'((n % 256) * (2 * (n / 256) + 1)), n == 0, 64'd0);
      end
      send_item(CMD_SYMBOL, 8'h00, 1'b1, 64'd0);
      send_item(CMD_SYMBOL, 8'h00, 1'b0, 64'd0);
      send_item(CMD_QUERY, 8'h00, 1'b0, 64'h0001);
      send_item(CMD_QUERY, 8'h00, 1'b0, 64'h0009);
      send_item(CMD_CLEAR, 8'h00, 1'b0, 64'd0);
      wait_for_results();
      repeat (20) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
